// ===== hdl/aapr_pkg.sv =====
// shared types, constants and the arctangent table for the axis-angle rotation block
`timescale 1ns / 1ps
package aapr_pkg;

  // angle constants in Q2.30
  localparam logic [45:0]        TWO_PI_Q30  = 46'h0001921FB544;
  localparam logic signed [34:0] TWO_PI_S    = 35'sh1921FB544;
  localparam logic signed [34:0] PI_S        = 35'sh0C90FDAA2;
  localparam logic signed [34:0] HALF_PI_S   = 35'sh06487ED51;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
  localparam logic signed [34:0] ONE_Q30     = 35'sh040000000;

  // square root cell state
  typedef struct packed {
    logic [63:0] v;
    logic [35:0] rem;
    logic [31:0] root;
  } sqrt_st_t;

  // divider cell state
  typedef struct packed {
    logic [32:0] rem;
    logic [30:0] quot;
    logic [31:0] mag;
    logic [31:0] phi;
  } div_st_t;

  // cordic cell state
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               flip;
  } cordic_st_t;

  // atan(2^-i) in Q2.30, zero past the table
  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] a;
    unique case (i)
      0:  a = 34'sh03243F6A8;
      1:  a = 34'sh01DAC6705;
      2:  a = 34'sh00FADBAFC;
      3:  a = 34'sh007F56EA6;
      4:  a = 34'sh003FEAB76;
      5:  a = 34'sh001FFD55B;
      6:  a = 34'sh000FFFAAA;
      7:  a = 34'sh0007FFF55;
      8:  a = 34'sh0003FFFEA;
      9:  a = 34'sh0001FFFFD;
      10: a = 34'sh0000FFFFF;
      11: a = 34'sh00007FFFF;
      12: a = 34'sh00003FFFF;
      13: a = 34'sh00001FFFF;
      14: a = 34'sh00000FFFF;
      15: a = 34'sh000007FFF;
      16: a = 34'sh000003FFF;
      17: a = 34'sh000001FFF;
      18: a = 34'sh000000FFF;
      19: a = 34'sh0000007FF;
      20: a = 34'sh0000003FF;
      21: a = 34'sh0000001FF;
      22: a = 34'sh0000000FF;
      23: a = 34'sh00000007F;
      24: a = 34'sh00000003F;
      25: a = 34'sh00000001F;
      26: a = 34'sh00000000F;
      27: a = 34'sh000000008;
      28: a = 34'sh000000004;
      29: a = 34'sh000000002;
      30: a = 34'sh000000001;
      default: a = 34'sh000000000;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/aapr_delay.sv =====
// enabled shift line that carries side data alongside the arithmetic cells
`timescale 1ns / 1ps
module aapr_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  generate
    if (DEPTH == 0) begin : g_none
      assign dout = din;
    end else begin : g_line
      logic [W-1:0] taps [DEPTH];

      // shift one tap per enabled cycle
      always_ff @(posedge clk) begin
        if (en) begin
          taps[0] <= din;
          for (int k = 1; k < DEPTH; k++) begin
            taps[k] <= taps[k-1];
          end
        end
      end

      assign dout = taps[DEPTH-1];
    end
  endgenerate

endmodule

// ===== hdl/aapr_sqrt_cell.sv =====
// one result bit of the restoring integer square root
`timescale 1ns / 1ps
module aapr_sqrt_cell
  import aapr_pkg::*;
#(
  parameter int J = 31
) (
  input  logic     clk,
  input  logic     en,
  input  sqrt_st_t sin,
  output sqrt_st_t sout
);

  logic [35:0] shifted;
  logic [35:0] trial;
  sqrt_st_t    nxt;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    shifted  = {sin.rem[33:0], sin.v[2*J+1 -: 2]};
    trial    = {2'b00, sin.root, 2'b01};
    nxt      = sin;
    if (shifted >= trial) begin
      nxt.rem  = shifted - trial;
      nxt.root = {sin.root[30:0], 1'b1};
    end else begin
      nxt.rem  = shifted;
      nxt.root = {sin.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sout <= nxt;
    end
  end

endmodule

// ===== hdl/aapr_div_cell.sv =====
// one quotient bit of the restoring divider for the unit axis
`timescale 1ns / 1ps
module aapr_div_cell
  import aapr_pkg::*;
#(
  parameter int J = 30
) (
  input  logic    clk,
  input  logic    en,
  input  div_st_t din,
  output div_st_t dout
);

  logic    nbit;
  logic [32:0] shifted;
  div_st_t nxt;

  // dividend is mag shifted up by 30, so only the top cell sees a mag bit
  always_comb begin
    nbit    = (J == 30) ? din.mag[0] : 1'b0;
    shifted = {din.rem[31:0], nbit};
    nxt     = din;
    if (shifted >= {1'b0, din.phi}) begin
      nxt.rem  = shifted - {1'b0, din.phi};
      nxt.quot = {din.quot[29:0], 1'b1};
    end else begin
      nxt.rem  = shifted;
      nxt.quot = {din.quot[29:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

// ===== hdl/aapr_cordic_cell.sv =====
// one rotation-mode cordic micro-rotation
`timescale 1ns / 1ps
module aapr_cordic_cell
  import aapr_pkg::*;
#(
  parameter int I = 0
) (
  input  logic       clk,
  input  logic       en,
  input  cordic_st_t cin,
  output cordic_st_t cout
);

  logic signed [33:0] dx;
  logic signed [33:0] dy;
  cordic_st_t         nxt;

  // floor shifts, direction from the residual angle sign
  always_comb begin
    dx  = cin.y >>> I;
    dy  = cin.x >>> I;
    nxt = cin;
    if (!cin.z[33]) begin
      nxt.x = cin.x - dx;
      nxt.y = cin.y + dy;
      nxt.z = cin.z - atan_q30(I);
    end else begin
      nxt.x = cin.x + dx;
      nxt.y = cin.y - dy;
      nxt.z = cin.z + atan_q30(I);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cout <= nxt;
    end
  end

endmodule

// ===== hdl/axis_angle_point_rotation.sv =====
// top level: rotates a point about an axis through a pivot (rodrigues formula)
//
//   channel   signals                              direction
//   input     in_valid, in_ready, point_*, axis_*, pivot_*   in
//   output    out_valid, out_ready, rotated_*      out
//
// one point per cycle sustained while out_ready is high
// the pipe is built from the 32 square root cells, the 31 divider cells and the
// angle reduction plus cordic chain, followed by five multiply/add stages
// reset clears only the valid line; the whole pipe holds while a result waits
// a stalled output stops every stage together, in_ready follows that enable
`timescale 1ns / 1ps
module axis_angle_point_rotation
  import aapr_pkg::*;
#(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic signed [31:0] axis_x,
  input  logic signed [31:0] axis_y,
  input  logic signed [31:0] axis_z,
  input  logic signed [31:0] pivot_x,
  input  logic signed [31:0] pivot_y,
  input  logic signed [31:0] pivot_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] rotated_x,
  output logic signed [31:0] rotated_y,
  output logic signed [31:0] rotated_z
);

  localparam int ANG_LAT = 16 + CORDIC_STAGES;
  localparam int M       = (ANG_LAT > 31) ? ANG_LAT : 31;
  localparam int LAT     = 40 + M;

  logic           en;
  logic [LAT-1:0] vld;

  // pipe enable and valid line
  assign en        = !vld[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  logic signed [31:0] a_in [3];
  logic signed [31:0] p_in [3];
  logic signed [31:0] q_in [3];
  assign a_in[0] = axis_x;  assign a_in[1] = axis_y;  assign a_in[2] = axis_z;
  assign p_in[0] = point_x; assign p_in[1] = point_y; assign p_in[2] = point_z;
  assign q_in[0] = pivot_x; assign q_in[1] = pivot_y; assign q_in[2] = pivot_z;

  // magnitudes, squares and the squared length
  logic [31:0] mag [3];
  logic [2:0]  sgn;
  logic [63:0] sq [3];
  logic [63:0] sum;
  logic        zero;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mag[k] <= a_in[k][31] ? 32'(-a_in[k]) : 32'(a_in[k]);
        sgn[k] <= a_in[k][31];
        sq[k]  <= mag[k] * mag[k];
      end
      sum <= sq[0] + sq[1] + sq[2];
    end
  end

  assign zero = (sum == 64'd0);

  // square root chain
  sqrt_st_t sq_st [33];
  assign sq_st[0] = '{v: sum, rem: '0, root: '0};

  generate
    for (genvar g = 0; g < 32; g++) begin : g_sqrt
      aapr_sqrt_cell #(.J(31 - g)) u_cell (
        .clk (clk),
        .en  (en),
        .sin (sq_st[g]),
        .sout(sq_st[g+1])
      );
    end
  endgenerate

  logic [31:0] phi;
  assign phi = sq_st[32].root;

  // axis magnitudes and signs follow the square root
  logic [95:0] mag_d;
  logic [2:0]  sgn_d;

  aapr_delay #(.W(96), .DEPTH(34)) u_mag_dly (
    .clk (clk), .en(en), .din({mag[2], mag[1], mag[0]}), .dout(mag_d)
  );
  aapr_delay #(.W(3), .DEPTH(65)) u_sgn_dly (
    .clk (clk), .en(en), .din(sgn), .dout(sgn_d)
  );

  // unit axis dividers
  logic [95:0] n_raw;

  generate
    for (genvar k = 0; k < 3; k++) begin : g_div
      div_st_t st [32];
      assign st[0] = '{rem: {2'b00, mag_d[32*k+31 -: 31]}, quot: '0,
                       mag: mag_d[32*k +: 32], phi: phi};
      for (genvar g = 0; g < 31; g++) begin : g_cell
        aapr_div_cell #(.J(30 - g)) u_cell (
          .clk (clk),
          .en  (en),
          .din (st[g]),
          .dout(st[g+1])
        );
      end
      assign n_raw[32*k +: 32] = sgn_d[k] ? -{1'b0, st[31].quot} : {1'b0, st[31].quot};
    end
  endgenerate

  logic [95:0] n_al;
  aapr_delay #(.W(96), .DEPTH(M - 31)) u_n_dly (
    .clk (clk), .en(en), .din(n_raw), .dout(n_al)
  );

  // angle modulo two pi, one scaled subtract per stage
  logic [45:0] modv [15];
  assign modv[0] = {phi, 14'd0};

  generate
    for (genvar g = 0; g < 14; g++) begin : g_mod
      localparam logic [45:0] C = TWO_PI_Q30 << (13 - g);
      always_ff @(posedge clk) begin
        if (en) begin
          modv[g+1] <= (modv[g] >= C) ? modv[g] - C : modv[g];
        end
      end
    end
  endgenerate

  // fold into the cordic range
  logic signed [34:0] t0;
  logic signed [34:0] t1;
  logic signed [34:0] t2;
  logic               fl;
  cordic_st_t         cst [CORDIC_STAGES+1];

  always_comb begin
    t0 = $signed({2'b00, modv[14][32:0]});
    t1 = (t0 > PI_S) ? t0 - TWO_PI_S : t0;
    fl = 1'b0;
    t2 = t1;
    if (t1 > HALF_PI_S) begin
      t2 = t1 - PI_S;
      fl = 1'b1;
    end else if (t1 < -HALF_PI_S) begin
      t2 = t1 + PI_S;
      fl = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cst[0] <= '{x: CORDIC_GAIN, y: '0, z: t2[33:0], flip: fl};
    end
  end

  generate
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      aapr_cordic_cell #(.I(g)) u_cell (
        .clk (clk),
        .en  (en),
        .cin (cst[g]),
        .cout(cst[g+1])
      );
    end
  endgenerate

  // cosine, sine and one minus cosine
  logic signed [33:0] cr;
  logic signed [33:0] sr;
  logic signed [34:0] omcr;

  always_ff @(posedge clk) begin
    if (en) begin
      cr   <= cst[CORDIC_STAGES].flip ? -cst[CORDIC_STAGES].x : cst[CORDIC_STAGES].x;
      sr   <= cst[CORDIC_STAGES].flip ? -cst[CORDIC_STAGES].y : cst[CORDIC_STAGES].y;
      omcr <= ONE_Q30 - (cst[CORDIC_STAGES].flip ? -35'(cst[CORDIC_STAGES].x)
                                                  :  35'(cst[CORDIC_STAGES].x));
    end
  end

  logic [102:0] cs_al;
  aapr_delay #(.W(103), .DEPTH(M - ANG_LAT)) u_cs_dly (
    .clk (clk), .en(en), .din({omcr, sr, cr}), .dout(cs_al)
  );

  // offset from the pivot and the pivot itself ride along
  logic [194:0] rq_in;
  logic [194:0] rq_al;
  logic         zero_al;

  assign rq_in = {33'(p_in[2]) - 33'(q_in[2]), 33'(p_in[1]) - 33'(q_in[1]),
                  33'(p_in[0]) - 33'(q_in[0]), q_in[2], q_in[1], q_in[0]};

  aapr_delay #(.W(195), .DEPTH(35 + M)) u_rq_dly (
    .clk (clk), .en(en), .din(rq_in), .dout(rq_al)
  );
  aapr_delay #(.W(1), .DEPTH(32 + M)) u_zero_dly (
    .clk (clk), .en(en), .din(zero), .dout(zero_al)
  );

  logic signed [31:0] na [3];
  logic signed [32:0] ra [3];
  logic signed [31:0] qa [3];
  logic signed [33:0] ca;
  logic signed [33:0] sa;
  logic signed [34:0] oa;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      na[k] = $signed(n_al[32*k +: 32]);
      ra[k] = $signed(rq_al[96 + 33*k +: 33]);
      qa[k] = $signed(rq_al[32*k +: 32]);
    end
    ca = $signed(cs_al[33:0]);
    sa = $signed(cs_al[67:34]);
    oa = $signed(cs_al[102:68]);
  end

  // stage 1: axis-offset products and offset times cosine
  logic signed [64:0] p_dot [3];
  logic signed [64:0] p_ab  [3];
  logic signed [64:0] p_ba  [3];
  logic signed [66:0] p_rc  [3];

  logic signed [34:0] s1_dot [3];
  logic signed [34:0] s1_ab  [3];
  logic signed [34:0] s1_ba  [3];
  logic signed [36:0] s1_rc  [3];
  logic signed [31:0] s1_n   [3];
  logic signed [32:0] s1_r   [3];
  logic signed [31:0] s1_q   [3];
  logic signed [33:0] s1_s;
  logic signed [34:0] s1_omc;
  logic               s1_zero;

  generate
    for (genvar k = 0; k < 3; k++) begin : g_p1
      localparam int A = (k + 1) % 3;
      localparam int B = (k + 2) % 3;
      assign p_dot[k] = na[k] * ra[k];
      assign p_ab[k]  = na[A] * ra[B];
      assign p_ba[k]  = na[B] * ra[A];
      assign p_rc[k]  = ra[k] * ca;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s1_dot[k] <= p_dot[k][64:30];
        s1_ab[k]  <= p_ab[k][64:30];
        s1_ba[k]  <= p_ba[k][64:30];
        s1_rc[k]  <= p_rc[k][66:30];
        s1_n[k]   <= na[k];
        s1_r[k]   <= ra[k];
        s1_q[k]   <= qa[k];
      end
      s1_s    <= sa;
      s1_omc  <= oa;
      s1_zero <= zero_al;
    end
  end

  // stage 2: dot and cross products
  logic signed [36:0] s2_dot;
  logic signed [35:0] s2_cr  [3];
  logic signed [36:0] s2_rc  [3];
  logic signed [31:0] s2_n   [3];
  logic signed [32:0] s2_r   [3];
  logic signed [31:0] s2_q   [3];
  logic signed [33:0] s2_s;
  logic signed [34:0] s2_omc;
  logic               s2_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_dot <= 37'(s1_dot[0]) + 37'(s1_dot[1]) + 37'(s1_dot[2]);
      for (int k = 0; k < 3; k++) begin
        s2_cr[k] <= 36'(s1_ab[k]) - 36'(s1_ba[k]);
        s2_rc[k] <= s1_rc[k];
        s2_n[k]  <= s1_n[k];
        s2_r[k]  <= s1_r[k];
        s2_q[k]  <= s1_q[k];
      end
      s2_s    <= s1_s;
      s2_omc  <= s1_omc;
      s2_zero <= s1_zero;
    end
  end

  // stage 3: component along the axis and cross times sine
  logic signed [71:0] p_along;
  logic signed [69:0] p_crs [3];

  assign p_along = s2_dot * s2_omc;
  generate
    for (genvar k = 0; k < 3; k++) begin : g_p3
      assign p_crs[k] = s2_cr[k] * s2_s;
    end
  endgenerate

  logic signed [41:0] s3_along;
  logic signed [39:0] s3_crs [3];
  logic signed [36:0] s3_rc  [3];
  logic signed [31:0] s3_n   [3];
  logic signed [32:0] s3_r   [3];
  logic signed [31:0] s3_q   [3];
  logic               s3_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_along <= p_along[71:30];
      for (int k = 0; k < 3; k++) begin
        s3_crs[k] <= p_crs[k][69:30];
        s3_rc[k]  <= s2_rc[k];
        s3_n[k]   <= s2_n[k];
        s3_r[k]   <= s2_r[k];
        s3_q[k]   <= s2_q[k];
      end
      s3_zero <= s2_zero;
    end
  end

  // stage 4: axis times along component
  logic signed [73:0] p_na [3];
  generate
    for (genvar k = 0; k < 3; k++) begin : g_p4
      assign p_na[k] = s3_n[k] * s3_along;
    end
  endgenerate

  logic signed [43:0] s4_na  [3];
  logic signed [39:0] s4_crs [3];
  logic signed [36:0] s4_rc  [3];
  logic signed [32:0] s4_r   [3];
  logic signed [31:0] s4_q   [3];
  logic               s4_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s4_na[k]  <= p_na[k][73:30];
        s4_crs[k] <= s3_crs[k];
        s4_rc[k]  <= s3_rc[k];
        s4_r[k]   <= s3_r[k];
        s4_q[k]   <= s3_q[k];
      end
      s4_zero <= s3_zero;
    end
  end

  // stage 5: final sum (the offset alone for a zero axis), pivot added back, saturate
  logic signed [45:0] tot [3];
  logic signed [31:0] sat [3];
  logic signed [31:0] res [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (s4_zero) begin
        tot[k] = 46'(s4_r[k]) + 46'(s4_q[k]);
      end else begin
        tot[k] = 46'(s4_rc[k]) + 46'(s4_na[k]) + 46'(s4_crs[k]) + 46'(s4_q[k]);
      end
      if (tot[k] > 46'sd2147483647) begin
        sat[k] = 32'sh7FFFFFFF;
      end else if (tot[k] < -46'sd2147483648) begin
        sat[k] = 32'sh80000000;
      end else begin
        sat[k] = tot[k][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        res[k] <= sat[k];
      end
    end
  end

  assign rotated_x = res[0];
  assign rotated_y = res[1];
  assign rotated_z = res[2];

  // square root result brackets the radicand
  assert property (@(posedge clk) disable iff (rst)
    vld[34] |-> (66'(sq_st[32].root) * 66'(sq_st[32].root) <= 66'(sq_st[32].v)))
    else $error("square root too large");

  assert property (@(posedge clk) disable iff (rst)
    vld[34] |-> ((66'(sq_st[32].root) + 66'd1) * (66'(sq_st[32].root) + 66'd1)
                 > 66'(sq_st[32].v)))
    else $error("square root too small");

  // reduced angle lies within a quarter turn
  assert property (@(posedge clk) disable iff (rst)
    vld[49] |-> (35'(cst[0].z) <= HALF_PI_S && 35'(cst[0].z) >= -HALF_PI_S))
    else $error("angle reduction out of range");

  // no result is shown in the cycle after reset
  assert property (@(posedge clk) (!rst && $past(rst)) |-> !out_valid)
    else $error("result valid right after reset");

  // a stalled pipe keeps its occupancy
  assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipe moved while stalled");

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the axis-angle point rotation block
`timescale 1ns / 1ps
module tb_top;
  import aapr_pkg::*;

  localparam int STAGES = 24;
  localparam int NUM_RANDOM = 400;

  typedef struct {
    logic signed [31:0] pt[3];
    logic signed [31:0] ax[3];
    logic signed [31:0] pv[3];
  } rot_item_t;

  typedef struct {
    logic signed [31:0] v[3];
  } coord_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
  logic signed [31:0] axis_x = '0, axis_y = '0, axis_z = '0;
  logic signed [31:0] pivot_x = '0, pivot_y = '0, pivot_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] rotated_x, rotated_y, rotated_z;

  rot_item_t pending_points[$];
  coord_t expected_coords[$];
  int sent_count = 0;
  int send_idle_pct = 35;
  int recv_idle_pct = 85;
  bit failed = 1'b0;

  axis_angle_point_rotation #(.CORDIC_STAGES(STAGES)) dut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // floor(a*b / 2^30) on the exact product
  function automatic longint mul_q30_floor(input longint a, input longint b);
    logic signed [127:0] wa, wb, pr;
    wa = a;
    wb = b;
    pr = wa * wb;
    return longint'(pr >>> 30);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // expected rotated point for one input transfer
  function automatic coord_t rotate_point(input rot_item_t it);
    coord_t res;
    longint unsigned mag[3], sum, phi, qn;
    longint nrm[3], rel[3], crs[3], t, x, y, z, dx, dy, c, s, omc, dot, along, val;
    bit flip;
    int sh;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = (it.ax[k] < 0) ? longint'(-longint'(it.ax[k])) : longint'(it.ax[k]);
      sum += mag[k] * mag[k];
    end
    if (sum == 0) begin
      for (int k = 0; k < 3; k++) res.v[k] = it.pt[k];
      return res;
    end
    phi = int_sqrt(sum);
    for (int k = 0; k < 3; k++) begin
      qn = (mag[k] << 30) / phi;
      nrm[k] = (it.ax[k] < 0) ? -longint'(qn) : longint'(qn);
      rel[k] = longint'(it.pt[k]) - longint'(it.pv[k]);
    end
    // angle reduction into [-pi/2, pi/2]
    t = longint'((phi << 14) % longint'(TWO_PI_S));
    flip = 1'b0;
    if (t > longint'(PI_S)) t -= longint'(TWO_PI_S);
    if (t > longint'(HALF_PI_S)) begin
      t -= longint'(PI_S);
      flip = 1'b1;
    end else if (t < -longint'(HALF_PI_S)) begin
      t += longint'(PI_S);
      flip = 1'b1;
    end
    // rotation-mode cordic
    x = longint'(CORDIC_GAIN);
    y = 0;
    z = t;
    for (int i = 0; i < STAGES; i++) begin
      sh = (i < 63) ? i : 63;
      dx = y >>> sh;
      dy = x >>> sh;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_q30(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_q30(i));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    omc = longint'(ONE_Q30) - c;
    dot = mul_q30_floor(nrm[0], rel[0]) + mul_q30_floor(nrm[1], rel[1])
        + mul_q30_floor(nrm[2], rel[2]);
    crs[0] = mul_q30_floor(nrm[1], rel[2]) - mul_q30_floor(nrm[2], rel[1]);
    crs[1] = mul_q30_floor(nrm[2], rel[0]) - mul_q30_floor(nrm[0], rel[2]);
    crs[2] = mul_q30_floor(nrm[0], rel[1]) - mul_q30_floor(nrm[1], rel[0]);
    along = mul_q30_floor(dot, omc);
    for (int k = 0; k < 3; k++) begin
      val = mul_q30_floor(rel[k], c) + mul_q30_floor(nrm[k], along)
          + mul_q30_floor(crs[k], s) + longint'(it.pv[k]);
      if (val > 64'sd2147483647) val = 64'sd2147483647;
      if (val < -64'sd2147483648) val = -64'sd2147483648;
      res.v[k] = val[31:0];
    end
    return res;
  endfunction

  function automatic rot_item_t mk_item(input int px, py, pz, ax, ay, az, qx, qy, qz);
    rot_item_t it;
    it.pt = '{px, py, pz};
    it.ax = '{ax, ay, az};
    it.pv = '{qx, qy, qz};
    return it;
  endfunction

  function automatic int rand_bits(input int w);
    int v;
    v = int'($urandom);
    if (w >= 32) return v;
    return v >>> (32 - w);
  endfunction

  // driver: presents queued points, records expectations on each transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_coords.push_back(rotate_point(mk_item(point_x, point_y, point_z,
          axis_x, axis_y, axis_z, pivot_x, pivot_y, pivot_z)));
        sent_count <= sent_count + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          rot_item_t it;
          it = pending_points.pop_front();
          {point_x, point_y, point_z} <= {it.pt[0], it.pt[1], it.pt[2]};
          {axis_x, axis_y, axis_z} <= {it.ax[0], it.ax[1], it.ax[2]};
          {pivot_x, pivot_y, pivot_z} <= {it.pv[0], it.pv[1], it.pv[2]};
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each output transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_coords.size() == 0) begin
          $display("%0t: unexpected result %h %h %h", $time, rotated_x, rotated_y,
                   rotated_z);
          failed = 1'b1;
        end else begin
          coord_t exp_c;
          exp_c = expected_coords.pop_front();
          if (rotated_x !== exp_c.v[0]) begin
            $display("%0t: rotated_x expected %h actual %h", $time, exp_c.v[0], rotated_x);
            failed = 1'b1;
          end
          if (rotated_y !== exp_c.v[1]) begin
            $display("%0t: rotated_y expected %h actual %h", $time, exp_c.v[1], rotated_y);
            failed = 1'b1;
          end
          if (rotated_z !== exp_c.v[2]) begin
            $display("%0t: rotated_z expected %h actual %h", $time, exp_c.v[2], rotated_z);
            failed = 1'b1;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // idle pattern follows progress through the stimulus
  always @(posedge clk) begin
    if (sent_count >= 2 * (NUM_RANDOM + 20) / 3) begin
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
    end else if (sent_count >= (NUM_RANDOM + 20) / 3) begin
      send_idle_pct <= 85;
      recv_idle_pct <= 35;
    end
  end

  // stimulus and end of run
  initial begin
    int kind;
    rot_item_t it;
    // directed: zero vector, extremes, axis directions, special angles, saturation
    pending_points.push_back(mk_item(32'h7FFFFFFF, 32'h80000000, 12345, 0, 0, 0, 7, 8, 9));
    pending_points.push_back(mk_item(32'h80000000, 32'h7FFFFFFF, -1, 0, 0, 0,
                                     32'h80000000, 32'h7FFFFFFF, 0));
    pending_points.push_back(mk_item(65536, 0, 0, 0, 0, 65536, 0, 0, 0));
    pending_points.push_back(mk_item(0, 65536, 0, 65536, 0, 0, 0, 0, 0));
    pending_points.push_back(mk_item(0, 0, 65536, 0, 65536, 0, 0, 0, 0));
    pending_points.push_back(mk_item(65536, 65536, 65536, 0, 0, 102944, 0, 0, 0));
    pending_points.push_back(mk_item(65536, 2 * 65536, 0, 0, 0, 205887, 0, 0, 0));
    pending_points.push_back(mk_item(65536, 2 * 65536, 3, 0, 0, 411775, 0, 0, 0));
    pending_points.push_back(mk_item(65536, -65536, 5, -205887, 0, 0, 65536, 0, 0));
    pending_points.push_back(mk_item(100, 200, 300, 1, 0, 0, 0, 0, 0));
    pending_points.push_back(mk_item(100, 200, 300, 0, -1, 1, 4, 5, 6));
    pending_points.push_back(mk_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000));
    pending_points.push_back(mk_item(32'h80000000, 32'h80000000, 32'h80000000,
      32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
    pending_points.push_back(mk_item(32'h7FFFFFFF, 0, 0, 0, 0, 205887,
                                     32'h80000000, 0, 0));
    pending_points.push_back(mk_item(32'h80000000, 0, 0, 0, 0, 205887,
                                     32'h7FFFFFFF, 0, 0));
    pending_points.push_back(mk_item(32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 51472, 0, 0, 0));
    pending_points.push_back(mk_item(1000, 2000, 3000, 65536, 65536, 65536,
                                     1000, 2000, 3000));
    pending_points.push_back(mk_item(-5000, 7000, 9, 32'h80000000, 0, 0, 0, 0, 0));
    pending_points.push_back(mk_item(5000, -7000, 9, 0, 32'h7FFFFFFF, 0, 0, 0, 0));
    pending_points.push_back(mk_item(5000, -7000, 9, 0, 0, -102944, -3, -4, -5));
    // random: mostly moderate geometry, some full range and zero vectors
    for (int n = 0; n < NUM_RANDOM; n++) begin
      kind = $urandom_range(9);
      for (int k = 0; k < 3; k++) begin
        if (kind < 2) begin
          it.pt[k] = rand_bits(32);
          it.ax[k] = rand_bits(32);
          it.pv[k] = rand_bits(32);
        end else begin
          it.pt[k] = rand_bits(24);
          it.ax[k] = (kind == 9) ? 0 : rand_bits($urandom_range(4, 22));
          it.pv[k] = rand_bits(22);
        end
      end
      pending_points.push_back(it);
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (pending_points.size() > 0 || in_valid || expected_coords.size() > 0);
    repeat (200) @(posedge clk);
    if (!failed && expected_coords.size() == 0) begin
      $display("** axis_angle_point_rotation: PASSED **");
    end else begin
      $display("** axis_angle_point_rotation: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("** axis_angle_point_rotation: FAILED **");
    $finish;
  end

endmodule
